// ----- hw/rtl/trpn_pkg.sv -----
// shared types, command and status codes for the typed rpn stack engine
package trpn_pkg;

   localparam int OP_W    = 5;
   localparam int VAL_W   = 32;
   localparam int ST_W    = 3;
   localparam int DEPTH_W = 7;
   localparam int CNT_W   = $clog2(VAL_W);

   // command codes
   localparam logic [OP_W-1:0] OP_PUSH_INT  = 5'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BOOL = 5'd1;
   localparam logic [OP_W-1:0] OP_CLEAR     = 5'd2;
   localparam logic [OP_W-1:0] OP_NOT       = 5'd3;
   localparam logic [OP_W-1:0] OP_PRINT     = 5'd4;
   localparam logic [OP_W-1:0] OP_DROP      = 5'd5;
   localparam logic [OP_W-1:0] OP_DUP       = 5'd6;
   localparam logic [OP_W-1:0] OP_SWAP      = 5'd7;
   localparam logic [OP_W-1:0] OP_ADD       = 5'd8;
   localparam logic [OP_W-1:0] OP_SUB       = 5'd9;
   localparam logic [OP_W-1:0] OP_MUL       = 5'd10;
   localparam logic [OP_W-1:0] OP_DIV       = 5'd11;
   localparam logic [OP_W-1:0] OP_MOD       = 5'd12;
   localparam logic [OP_W-1:0] OP_LT        = 5'd13;
   localparam logic [OP_W-1:0] OP_GT        = 5'd14;
   localparam logic [OP_W-1:0] OP_LE        = 5'd15;
   localparam logic [OP_W-1:0] OP_GE        = 5'd16;
   localparam logic [OP_W-1:0] OP_EQ        = 5'd17;

   // status codes
   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [ST_W-1:0] ST_NOT_INT  = 3'd2;
   localparam logic [ST_W-1:0] ST_NOT_BOOL = 3'd3;
   localparam logic [ST_W-1:0] ST_DIV_ZERO = 3'd4;
   localparam logic [ST_W-1:0] ST_OVERFLOW = 3'd5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FETCH,
      S_ALU,
      S_MUL,
      S_ABS_A,
      S_ABS_B,
      S_DIV,
      S_FIX,
      S_RELOAD
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic signed [VAL_W-1:0] operand_value;
   } req_word_type;

   typedef struct packed {
      logic [ST_W-1:0]         status;
      logic                    top_valid;
      logic signed [VAL_W-1:0] top_value;
      logic                    top_is_bool;
      logic [DEPTH_W-1:0]      stack_depth;
   } rsp_word_type;

endpackage

// ----- hw/rtl/typed_rpn_stack_engine.sv -----
// typed rpn stack engine: stack memory, cached top entry and shared add/sub sequencer
// sequencing: push, clear, not, print, dup, unused codes and early errors answer from idle;
//    drop, swap, eq on two or more entries and a bool second operand answer from fetch; add,
//    sub, compares via fetch and alu, divide by zero via fetch and reload, mul via fetch and 32
//    shift-add steps, div and mod via fetch, two magnitude steps, 32 quotient bits and sign fix
// throughput: one command at a time, busy drops with the one-cycle strobe, which cannot stall
// reset: synchronous, clears the stack pointer, sequencer and strobe; entries are not cleared
module typed_rpn_stack_engine #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  trpn_pkg::req_word_type req_word,
   output logic                   rsp_strobe,
   output trpn_pkg::rsp_word_type rsp_word
);
   import trpn_pkg::*;

   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W = $clog2(STACK_DEPTH);
   localparam logic [PTR_W-1:0] SP_FULL  = PTR_W'(STACK_DEPTH);
   localparam logic [PTR_W-1:0] SP_ONE   = PTR_W'(1);
   localparam logic [PTR_W-1:0] SP_TWO   = PTR_W'(2);
   localparam logic [PTR_W-1:0] SP_THREE = PTR_W'(3);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VAL_W - 1);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   // sequencer and stack control
   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   sp_ff, sp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [ST_W-1:0]    status_ff, status_in;

   // top of stack lives in registers, entries below it in memory
   logic [VAL_W-1:0]   top_val_ff, top_val_in;
   logic               top_bool_ff, top_bool_in;

   // command and shared-unit working registers
   logic [OP_W-1:0]    op_ff, op_in;
   logic [VAL_W-1:0]   opa_ff, opa_in;
   logic [VAL_W-1:0]   opb_ff, opb_in;
   logic [VAL_W-1:0]   acc_ff, acc_in;
   logic [VAL_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;

   // stack memory, entry is {bool tag, value}
   logic [VAL_W:0]     mem [STACK_DEPTH];
   logic [VAL_W:0]     rd_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [VAL_W:0]     wr_data;
   logic [VAL_W-1:0]   rd_val;
   logic               rd_bool;

   // shared adder / subtractor
   logic [VAL_W:0]     add_x, add_y, add_sum;
   logic               add_sub;

   logic [PTR_W-1:0]   sp_m1, sp_m2, sp_m3;
   logic               accept, is_empty, is_single, is_full, is_binary, go_fetch;
   logic               cmp_lt, cmp_eq, cmp_res;
   logic [OP_W-1:0]    req_op;

   assign sp_m1     = sp_ff - SP_ONE;
   assign sp_m2     = sp_ff - SP_TWO;
   assign sp_m3     = sp_ff - SP_THREE;
   assign is_empty  = (sp_ff == '0);
   assign is_single = (sp_ff == SP_ONE);
   assign is_full   = (sp_ff == SP_FULL);
   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign req_op    = req_word.opcode;
   assign is_binary = req_op inside {[OP_ADD:OP_GE]};
   assign rd_val    = rd_ff[VAL_W-1:0];
   assign rd_bool   = rd_ff[VAL_W];

   // commands that need the second entry go through the fetch cycle
   always_comb begin
      go_fetch = 1'b0;
      if (accept && !is_empty && !is_single) begin
         if (req_op == OP_DROP || req_op == OP_SWAP || req_op == OP_EQ) begin
            go_fetch = 1'b1;
         end else if (is_binary && !top_bool_ff) begin
            go_fetch = 1'b1;
         end
      end
   end

   // shared unit operand select
   always_comb begin
      add_x   = '0;
      add_y   = '0;
      add_sub = 1'b0;
      case (state_ff)
         S_ALU: begin
            add_x   = {opa_ff[VAL_W-1], opa_ff};
            add_y   = {opb_ff[VAL_W-1], opb_ff};
            add_sub = (op_ff != OP_ADD);
         end
         S_MUL: begin
            add_x = {1'b0, acc_ff};
            add_y = quo_ff[0] ? {1'b0, opa_ff} : '0;
         end
         S_ABS_A: begin
            add_y   = {1'b0, opa_ff};
            add_sub = 1'b1;
         end
         S_ABS_B: begin
            add_y   = {1'b0, opb_ff};
            add_sub = 1'b1;
         end
         S_DIV: begin
            // trial subtract of the shifted partial remainder
            add_x   = {acc_ff, quo_ff[VAL_W-1]};
            add_y   = {1'b0, opb_ff};
            add_sub = 1'b1;
         end
         S_FIX: begin
            add_y   = {1'b0, (op_ff == OP_DIV) ? quo_ff : acc_ff};
            add_sub = 1'b1;
         end
         default: begin
            add_sub = 1'b0;
         end
      endcase
   end

   assign add_sum = add_x + (add_sub ? ~add_y : add_y) + {{VAL_W{1'b0}}, add_sub};

   // signed compare from the 33-bit difference
   assign cmp_lt = add_sum[VAL_W];
   assign cmp_eq = (add_sum == '0);

   always_comb begin
      case (op_ff)
         OP_LT:   cmp_res = cmp_lt;
         OP_GT:   cmp_res = !cmp_lt && !cmp_eq;
         OP_LE:   cmp_res = cmp_lt || cmp_eq;
         default: cmp_res = !cmp_lt;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (go_fetch) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            state_in = S_IDLE;
            if ((op_ff inside {[OP_ADD:OP_GE]}) && !rd_bool) begin
               case (op_ff)
                  OP_MUL:         state_in = S_MUL;
                  OP_DIV, OP_MOD: state_in = (opb_ff == '0) ? S_RELOAD : S_ABS_A;
                  default:        state_in = S_ALU;
               endcase
            end
         end
         S_ALU:    state_in = S_IDLE;
         S_MUL:    state_in = (cnt_ff == CNT_LAST) ? S_IDLE : S_MUL;
         S_ABS_A:  state_in = S_ABS_B;
         S_ABS_B:  state_in = S_DIV;
         S_DIV:    state_in = (cnt_ff == CNT_LAST) ? S_FIX : S_DIV;
         S_FIX:    state_in = S_IDLE;
         S_RELOAD: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath, memory port and response
   always_comb begin
      sp_in         = sp_ff;
      top_val_in    = top_val_ff;
      top_bool_in   = top_bool_ff;
      op_in         = op_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      rsp_strobe_in = 1'b0;
      status_in     = status_ff;
      wr_en         = 1'b0;
      wr_addr       = sp_m1[IDX_W-1:0];
      wr_data       = {top_bool_ff, top_val_ff};
      rd_addr       = sp_m2[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = req_op;
               opb_in        = top_val_ff;
               rsp_strobe_in = !go_fetch;
               status_in     = ST_OK;
               if (req_op == OP_PUSH_INT || req_op == OP_PUSH_BOOL) begin
                  if (is_full) begin
                     status_in = ST_OVERFLOW;
                  end else begin
                     // spill old top below the new one
                     wr_en       = !is_empty;
                     sp_in       = sp_ff + SP_ONE;
                     top_bool_in = (req_op == OP_PUSH_BOOL);
                     top_val_in  = (req_op == OP_PUSH_BOOL) ?
                                   {{(VAL_W-1){1'b0}}, req_word.operand_value[0]} :
                                   req_word.operand_value;
                  end
               end else if (req_op == OP_CLEAR) begin
                  sp_in = '0;
               end else if (req_op > OP_EQ) begin
                  status_in = ST_OK;
               end else if (is_empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  case (req_op)
                     OP_NOT: begin
                        if (!top_bool_ff) begin
                           status_in = ST_NOT_BOOL;
                        end else begin
                           top_val_in = top_val_ff ^ {{(VAL_W-1){1'b0}}, 1'b1};
                        end
                     end
                     OP_DUP: begin
                        if (is_full) begin
                           status_in = ST_OVERFLOW;
                        end else begin
                           wr_en = 1'b1;
                           sp_in = sp_ff + SP_ONE;
                        end
                     end
                     OP_DROP: begin
                        if (is_single) begin
                           sp_in = '0;
                        end
                     end
                     OP_SWAP: begin
                        if (is_single) begin
                           status_in = ST_EMPTY;
                        end
                     end
                     OP_EQ: begin
                        if (is_single) begin
                           sp_in     = '0;
                           status_in = ST_EMPTY;
                        end
                     end
                     OP_PRINT: begin
                        status_in = ST_OK;
                     end
                     default: begin
                        // binary integer ops
                        if (top_bool_ff) begin
                           status_in = ST_NOT_INT;
                        end else if (is_single) begin
                           sp_in     = '0;
                           status_in = ST_EMPTY;
                        end
                     end
                  endcase
               end
            end
         end

         S_FETCH: begin
            // rd_ff holds the second entry; prefetch the third for the div-by-zero path
            rd_addr   = sp_m3[IDX_W-1:0];
            status_in = ST_OK;
            case (op_ff)
               OP_DROP: begin
                  sp_in         = sp_m1;
                  top_val_in    = rd_val;
                  top_bool_in   = rd_bool;
                  rsp_strobe_in = 1'b1;
               end
               OP_SWAP: begin
                  wr_en         = 1'b1;
                  wr_addr       = sp_m2[IDX_W-1:0];
                  top_val_in    = rd_val;
                  top_bool_in   = rd_bool;
                  rsp_strobe_in = 1'b1;
               end
               OP_EQ: begin
                  sp_in         = sp_m1;
                  top_bool_in   = 1'b1;
                  top_val_in    = {{(VAL_W-1){1'b0}},
                                   (top_bool_ff == rd_bool) && (top_val_ff == rd_val)};
                  rsp_strobe_in = 1'b1;
               end
               default: begin
                  if (rd_bool) begin
                     // second operand stays, popped top is lost
                     sp_in         = sp_m1;
                     top_val_in    = rd_val;
                     top_bool_in   = rd_bool;
                     status_in     = ST_NOT_INT;
                     rsp_strobe_in = 1'b1;
                  end else begin
                     opa_in = rd_val;
                     acc_in = '0;
                     quo_in = opb_ff;
                     cnt_in = '0;
                     neg_in = (op_ff == OP_DIV) ? (rd_val[VAL_W-1] ^ opb_ff[VAL_W-1]) :
                                                  rd_val[VAL_W-1];
                     if ((op_ff == OP_DIV || op_ff == OP_MOD) && opb_ff == '0) begin
                        sp_in = sp_m2;
                     end
                  end
               end
            endcase
         end

         S_ALU: begin
            sp_in         = sp_m1;
            rsp_strobe_in = 1'b1;
            if (op_ff == OP_ADD || op_ff == OP_SUB) begin
               top_val_in  = add_sum[VAL_W-1:0];
               top_bool_in = 1'b0;
            end else begin
               top_val_in  = {{(VAL_W-1){1'b0}}, cmp_res};
               top_bool_in = 1'b1;
            end
         end

         S_MUL: begin
            // shift-add, low word of the product
            acc_in = add_sum[VAL_W-1:0];
            opa_in = {opa_ff[VAL_W-2:0], 1'b0};
            quo_in = {1'b0, quo_ff[VAL_W-1:1]};
            cnt_in = cnt_ff + CNT_ONE;
            if (cnt_ff == CNT_LAST) begin
               sp_in         = sp_m1;
               top_val_in    = add_sum[VAL_W-1:0];
               top_bool_in   = 1'b0;
               rsp_strobe_in = 1'b1;
            end
         end

         S_ABS_A: begin
            // dividend magnitude goes into the quotient shifter
            quo_in = opa_ff[VAL_W-1] ? add_sum[VAL_W-1:0] : opa_ff;
            acc_in = '0;
         end

         S_ABS_B: begin
            opb_in = opb_ff[VAL_W-1] ? add_sum[VAL_W-1:0] : opb_ff;
            cnt_in = '0;
         end

         S_DIV: begin
            // restoring step, one quotient bit
            quo_in = {quo_ff[VAL_W-2:0], !add_sum[VAL_W]};
            acc_in = add_sum[VAL_W] ? add_x[VAL_W-1:0] : add_sum[VAL_W-1:0];
            cnt_in = cnt_ff + CNT_ONE;
         end

         S_FIX: begin
            sp_in         = sp_m1;
            top_bool_in   = 1'b0;
            rsp_strobe_in = 1'b1;
            if (neg_ff) begin
               top_val_in = add_sum[VAL_W-1:0];
            end else begin
               top_val_in = (op_ff == OP_DIV) ? quo_ff : acc_ff;
            end
         end

         S_RELOAD: begin
            // both operands dropped, third entry becomes top
            top_val_in    = rd_val;
            top_bool_in   = rd_bool;
            status_in     = ST_DIV_ZERO;
            rsp_strobe_in = 1'b1;
         end

         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sp_ff         <= sp_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      top_val_ff  <= top_val_in;
      top_bool_ff <= top_bool_in;
      op_ff       <= op_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
   end

   // stack memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   // response view of the top entry, zeroed when empty
   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_word.status       = status_ff;
   assign rsp_word.top_valid    = !is_empty;
   assign rsp_word.top_value    = is_empty ? '0 : top_val_ff;
   assign rsp_word.top_is_bool  = !is_empty && top_bool_ff;
   assign rsp_word.stack_depth  = DEPTH_W'(sp_ff);

endmodule

// ----- hw/rtl/trpn_checker.sv -----
// port-level checks for the typed rpn stack engine, bound to the top level
module trpn_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input trpn_pkg::req_word_type req_word,
   input logic                   rsp_strobe,
   input trpn_pkg::rsp_word_type rsp_word
);
   import trpn_pkg::*;

   // engine is free again in the cycle it answers
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response strobe while busy");

   a_top_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.top_valid == (rsp_word.stack_depth != '0)))
      else $error("top_valid disagrees with depth");

   a_empty_view: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_word.top_valid) |->
         (rsp_word.top_value == '0 && !rsp_word.top_is_bool))
      else $error("empty stack shows a top entry");

   // push, clear and print answer in the cycle after they are accepted
   a_quick_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_word.opcode == OP_PUSH_INT ||
                          req_word.opcode == OP_PUSH_BOOL ||
                          req_word.opcode == OP_CLEAR ||
                          req_word.opcode == OP_PRINT)) |=> rsp_strobe)
      else $error("quick command did not answer in one cycle");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_word.opcode == OP_CLEAR) |=>
         (rsp_word.stack_depth == '0 && rsp_word.status == ST_OK))
      else $error("clear left entries or flagged an error");

endmodule

bind typed_rpn_stack_engine trpn_checker u_trpn_checker (.*);

// ----- sim/tb_typed_rpn_stack_engine.sv -----
// self-checking testbench for the typed rpn stack engine: directed table, then random sequences
`timescale 1ns / 100ps

module tb_typed_rpn_stack_engine;
   import trpn_pkg::*;

   localparam int STACK_DEPTH    = 64;
   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 10;
   // the watchdog limit lies far above the longest command, so reaching it means a hang
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_WORDS   = 1000;

   localparam logic [VAL_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [VAL_W-1:0] VAL_MAX  = 32'h7fff_ffff;
   localparam logic [VAL_W-1:0] VAL_NEG1 = 32'hffff_ffff;
   localparam logic [OP_W-1:0]  OP_UNUSED_TOP = 5'd31;

   // one row of the directed table; view is only used when typed is set
   typedef struct {
      logic [OP_W-1:0]  op;
      logic [VAL_W-1:0] val;
      bit               typed;
      rsp_word_type     view;
   } cmd_row_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         start      = 1'b0;
   req_word_type req_word   = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   // shadow copy of the stack, advanced in the order words are accepted
   logic [VAL_W-1:0] shadow_value   [STACK_DEPTH];
   logic             shadow_is_bool [STACK_DEPTH];
   int unsigned      shadow_count = 0;

   // stack views still owed by the engine, oldest first
   rsp_word_type stack_views_due [$];

   // a directed row can override the predicted view with a hand-written one
   bit           typed_pending = 1'b0;
   rsp_word_type typed_view    = '0;

   int unsigned idle_pct     = 0;
   int unsigned cmds_sent    = 0;
   int unsigned rsp_count    = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatches   = 0;

   cmd_row_type directed_rows [$];

   always #CLK_HALF clock = ~clock;

   typed_rpn_stack_engine #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_strobe(rsp_strobe),
      .rsp_word  (rsp_word)
   );

   // ------------------------------------------------------------------
   // stack predictor
   // ------------------------------------------------------------------

   function automatic logic [ST_W-1:0] push_entry(input logic [VAL_W-1:0] v,
                                                  input logic is_bool);
      if (shadow_count >= STACK_DEPTH) return ST_OVERFLOW;
      shadow_value[shadow_count]   = v;
      shadow_is_bool[shadow_count] = is_bool;
      shadow_count++;
      return ST_OK;
   endfunction

   // runs one command on the shadow stack and returns its status
   function automatic logic [ST_W-1:0] exec_command(input logic [OP_W-1:0] op,
                                                    input logic [VAL_W-1:0] val);
      logic [VAL_W-1:0] a;
      logic [VAL_W-1:0] b;
      logic             b_bool;
      longint           sa;
      longint           sb;
      longint           q;
      if (op == OP_PUSH_INT) return push_entry(val, 1'b0);
      if (op == OP_PUSH_BOOL) return push_entry({31'd0, val[0]}, 1'b1);
      if (op == OP_CLEAR) begin
         shadow_count = 0;
         return ST_OK;
      end
      // unused opcodes leave everything alone
      if (op > OP_EQ) return ST_OK;
      if (shadow_count == 0) return ST_EMPTY;
      case (op)
         OP_NOT: begin
            if (!shadow_is_bool[shadow_count-1]) return ST_NOT_BOOL;
            shadow_value[shadow_count-1] ^= 32'd1;
            return ST_OK;
         end
         OP_PRINT: return ST_OK;
         OP_DROP: begin
            shadow_count--;
            return ST_OK;
         end
         OP_DUP: return push_entry(shadow_value[shadow_count-1],
                                   shadow_is_bool[shadow_count-1]);
         OP_SWAP: begin
            if (shadow_count < 2) return ST_EMPTY;
            b      = shadow_value[shadow_count-1];
            b_bool = shadow_is_bool[shadow_count-1];
            shadow_value[shadow_count-1]   = shadow_value[shadow_count-2];
            shadow_is_bool[shadow_count-1] = shadow_is_bool[shadow_count-2];
            shadow_value[shadow_count-2]   = b;
            shadow_is_bool[shadow_count-2] = b_bool;
            return ST_OK;
         end
         OP_EQ: begin
            // top is lost even when the second entry is missing
            b      = shadow_value[shadow_count-1];
            b_bool = shadow_is_bool[shadow_count-1];
            shadow_count--;
            if (shadow_count == 0) return ST_EMPTY;
            shadow_count--;
            return push_entry({31'd0, (b_bool == shadow_is_bool[shadow_count]) &&
                                      (b == shadow_value[shadow_count])}, 1'b1);
         end
         default: begin
            if (shadow_is_bool[shadow_count-1]) return ST_NOT_INT;
            b = shadow_value[shadow_count-1];
            shadow_count--;
            if (shadow_count == 0) return ST_EMPTY;
            if (shadow_is_bool[shadow_count-1]) return ST_NOT_INT;
            a = shadow_value[shadow_count-1];
            shadow_count--;
            sa = longint'($signed(a));
            sb = longint'($signed(b));
            case (op)
               OP_ADD: return push_entry(a + b, 1'b0);
               OP_SUB: return push_entry(a - b, 1'b0);
               OP_MUL: return push_entry(a * b, 1'b0);
               OP_DIV, OP_MOD: begin
                  if (b == '0) return ST_DIV_ZERO;
                  // 64-bit math keeps min / -1 from trapping; low half wraps back to min
                  q = (op == OP_DIV) ? sa / sb : sa % sb;
                  return push_entry(q[VAL_W-1:0], 1'b0);
               end
               OP_LT: return push_entry({31'd0, sa < sb}, 1'b1);
               OP_GT: return push_entry({31'd0, sa > sb}, 1'b1);
               OP_LE: return push_entry({31'd0, sa <= sb}, 1'b1);
               default: return push_entry({31'd0, sa >= sb}, 1'b1);
            endcase
         end
      endcase
   endfunction

   // status plus the view of the top entry after the command
   function automatic rsp_word_type apply_command(input logic [OP_W-1:0] op,
                                                  input logic [VAL_W-1:0] val);
      rsp_word_type r;
      r = '0;
      r.status      = exec_command(op, val);
      r.stack_depth = DEPTH_W'(shadow_count);
      if (shadow_count != 0) begin
         r.top_valid   = 1'b1;
         r.top_value   = shadow_value[shadow_count-1];
         r.top_is_bool = shadow_is_bool[shadow_count-1];
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // directed table helpers
   // ------------------------------------------------------------------

   function automatic cmd_row_type typed_row(input logic [OP_W-1:0] op,
                                             input logic [VAL_W-1:0] val,
                                             input logic [ST_W-1:0] st,
                                             input logic tv,
                                             input logic [VAL_W-1:0] tval,
                                             input logic tb,
                                             input int depth);
      cmd_row_type r;
      r.op   = op;
      r.val  = val;
      r.typed = 1'b1;
      r.view = '{status: st, top_valid: tv, top_value: tval, top_is_bool: tb,
                 stack_depth: DEPTH_W'(depth)};
      return r;
   endfunction

   function automatic cmd_row_type pred_row(input logic [OP_W-1:0] op,
                                            input logic [VAL_W-1:0] val);
      cmd_row_type r;
      r.op    = op;
      r.val   = val;
      r.typed = 1'b0;
      r.view  = '0;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // checking and watchdog
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("error at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // outputs sampled at the rising edge; the engine updates with nonblocking
   // assignments, so this block sees the values from the cycle that just ended
   always @(posedge clock) begin : watch_rsp
      rsp_word_type want;
      if (!reset) begin
         // a strobe always belongs to an earlier word, so check before predicting
         if (rsp_strobe) begin
            if (stack_views_due.size() == 0) begin
               report_mismatch($sformatf("response word %0d with nothing pending", rsp_count));
            end else begin
               want = stack_views_due.pop_front();
               if (rsp_word.status !== want.status)
                  report_mismatch($sformatf("word %0d status %0h, want %0h",
                                            rsp_count, rsp_word.status, want.status));
               if (rsp_word.top_valid !== want.top_valid)
                  report_mismatch($sformatf("word %0d top_valid %0b, want %0b",
                                            rsp_count, rsp_word.top_valid, want.top_valid));
               if (rsp_word.top_value !== want.top_value)
                  report_mismatch($sformatf("word %0d top_value %h, want %h",
                                            rsp_count, rsp_word.top_value, want.top_value));
               if (rsp_word.top_is_bool !== want.top_is_bool)
                  report_mismatch($sformatf("word %0d top_is_bool %0b, want %0b",
                                            rsp_count, rsp_word.top_is_bool,
                                            want.top_is_bool));
               if (rsp_word.stack_depth !== want.stack_depth)
                  report_mismatch($sformatf("word %0d stack_depth %0d, want %0d",
                                            rsp_count, rsp_word.stack_depth,
                                            want.stack_depth));
            end
            rsp_count++;
         end
         // accepted command word: advance the shadow stack
         if (start && !busy) begin
            want = apply_command(req_word.opcode, req_word.operand_value);
            if (typed_pending) want = typed_view;
            stack_views_due.push_back(want);
         end
         if (rsp_strobe || (start && !busy)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no activity for %0d cycles", WATCHDOG_LIMIT);
            $display("tb_typed_rpn_stack_engine failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------

   // called at a falling edge, returns at the falling edge after the accept,
   // so the shadow stack is already up to date when the caller looks at it
   task automatic send_word(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
      // random sender gap; junk on the bus while start is low
      while ($urandom_range(99) < idle_pct) begin
         start    <= 1'b0;
         req_word <= '{opcode: OP_W'($urandom), operand_value: $urandom};
         @(negedge clock);
      end
      start    <= 1'b1;
      req_word <= '{opcode: op, operand_value: val};
      do @(posedge clock); while (busy);
      if (op <= OP_EQ) cmds_sent++;
      @(negedge clock);
   endtask

   // operand mix: corner values often, small values for divides, otherwise anything
   function automatic logic [VAL_W-1:0] rand_operand();
      case ($urandom_range(7))
         0: return '0;
         1: return 32'd1;
         2: return VAL_NEG1;
         3: return VAL_MIN;
         4: return VAL_MAX;
         5: return VAL_W'($signed($urandom_range(15)) - 8);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] rand_push_op();
      return ($urandom_range(9) < 3) ? OP_PUSH_BOOL : OP_PUSH_INT;
   endfunction

   // fill to the top, then try everything that grows or works on a full stack
   task automatic fill_stack();
      while (shadow_count < STACK_DEPTH) send_word(rand_push_op(), rand_operand());
      send_word(OP_PUSH_INT, rand_operand());
      send_word(OP_PUSH_BOOL, rand_operand());
      send_word(OP_DUP, $urandom);
      send_word(OP_SWAP, $urandom);
      send_word(OP_W'($urandom_range(OP_ADD, OP_EQ)), $urandom);
      send_word(OP_CLEAR, $urandom);
   endtask

   task automatic run_random(input int unsigned until_count);
      int unsigned      pick;
      logic [OP_W-1:0]  op;
      while (cmds_sent < until_count) begin
         pick = $urandom_range(99);
         if (pick == 0) begin
            fill_stack();
         end else if (pick < 55) begin
            // well-formed binary sequence, occasionally with a bool operand
            send_word(OP_PUSH_INT, rand_operand());
            send_word(($urandom_range(9) == 0) ? OP_PUSH_BOOL : OP_PUSH_INT, rand_operand());
            send_word(OP_W'($urandom_range(OP_ADD, OP_EQ)), rand_operand());
            if ($urandom_range(1))
               send_word(OP_W'($urandom_range(OP_NOT, OP_SWAP)), $urandom);
         end else if (pick < 92) begin
            // single command, steered to keep the depth in a useful band
            if (shadow_count < 3 && $urandom_range(1)) op = rand_push_op();
            else if (shadow_count > 50 && $urandom_range(1)) op = OP_DROP;
            else if ($urandom_range(3) == 0) op = rand_push_op();
            else op = OP_W'($urandom_range(OP_NOT, OP_EQ));
            send_word(op, rand_operand());
         end else if (pick < 95) begin
            send_word(OP_CLEAR, $urandom);
         end else begin
            // noise: opcodes with no meaning
            send_word(OP_W'($urandom_range(OP_EQ + 1, OP_UNUSED_TOP)), $urandom);
         end
      end
   endtask

   initial begin : drive_stimulus
      int unsigned phase_pct [3];
      // sender idle percentages per random phase; the result side cannot stall
      phase_pct = '{0, 61, 34};

      // empty stack corners
      directed_rows.push_back(typed_row(OP_PRINT, '0, ST_EMPTY, 0, '0, 0, 0));
      directed_rows.push_back(typed_row(OP_DROP, '0, ST_EMPTY, 0, '0, 0, 0));
      directed_rows.push_back(typed_row(OP_ADD, '0, ST_EMPTY, 0, '0, 0, 0));
      directed_rows.push_back(typed_row(OP_EQ, '0, ST_EMPTY, 0, '0, 0, 0));
      directed_rows.push_back(typed_row(OP_CLEAR, VAL_NEG1, ST_OK, 0, '0, 0, 0));
      // swap and not on a single int
      directed_rows.push_back(typed_row(OP_PUSH_INT, VAL_MAX, ST_OK, 1, VAL_MAX, 0, 1));
      directed_rows.push_back(typed_row(OP_SWAP, '0, ST_EMPTY, 1, VAL_MAX, 0, 1));
      directed_rows.push_back(typed_row(OP_NOT, '0, ST_NOT_BOOL, 1, VAL_MAX, 0, 1));
      // max + 1 wraps to min
      directed_rows.push_back(typed_row(OP_PUSH_INT, 32'd1, ST_OK, 1, 32'd1, 0, 2));
      directed_rows.push_back(typed_row(OP_ADD, '0, ST_OK, 1, VAL_MIN, 0, 1));
      // min / -1 stays min, min % -1 is zero
      directed_rows.push_back(typed_row(OP_PUSH_INT, VAL_NEG1, ST_OK, 1, VAL_NEG1, 0, 2));
      directed_rows.push_back(typed_row(OP_DIV, '0, ST_OK, 1, VAL_MIN, 0, 1));
      directed_rows.push_back(typed_row(OP_PUSH_INT, VAL_NEG1, ST_OK, 1, VAL_NEG1, 0, 2));
      directed_rows.push_back(typed_row(OP_MOD, '0, ST_OK, 1, '0, 0, 1));
      // only bit 0 of the operand makes the bool
      directed_rows.push_back(typed_row(OP_PUSH_BOOL, 32'hffff_fffe, ST_OK, 1, '0, 1, 2));
      // bool on top of a binary op: stack untouched
      directed_rows.push_back(typed_row(OP_MUL, '0, ST_NOT_INT, 1, '0, 1, 2));
      directed_rows.push_back(typed_row(OP_NOT, '0, ST_OK, 1, 32'd1, 1, 2));
      directed_rows.push_back(pred_row(OP_SWAP, '0));
      // int top popped and lost, bool second stays
      directed_rows.push_back(typed_row(OP_SUB, '0, ST_NOT_INT, 1, 32'd1, 1, 1));
      // eq across types is false
      directed_rows.push_back(pred_row(OP_PUSH_INT, 32'd1));
      directed_rows.push_back(pred_row(OP_EQ, '0));
      // divide by zero drops both operands
      directed_rows.push_back(pred_row(OP_PUSH_INT, VAL_MIN));
      directed_rows.push_back(pred_row(OP_PUSH_INT, '0));
      directed_rows.push_back(typed_row(OP_DIV, '0, ST_DIV_ZERO, 1, '0, 1, 1));
      directed_rows.push_back(pred_row(OP_DUP, '0));
      directed_rows.push_back(pred_row(OP_EQ, '0));
      directed_rows.push_back(typed_row(OP_LT, '0, ST_NOT_INT, 1, 32'd1, 1, 1));
      directed_rows.push_back(typed_row(OP_GT, '0, ST_NOT_INT, 1, 32'd1, 1, 1));
      directed_rows.push_back(pred_row(OP_PUSH_INT, 32'd7));
      directed_rows.push_back(pred_row(OP_DUP, '0));
      directed_rows.push_back(pred_row(OP_LE, '0));
      // unused opcode with every bit set is a no-op
      directed_rows.push_back(typed_row(OP_UNUSED_TOP, VAL_NEG1, ST_OK, 1, 32'd1, 1, 2));
      directed_rows.push_back(typed_row(OP_GE, '0, ST_NOT_INT, 1, 32'd1, 1, 2));
      directed_rows.push_back(typed_row(OP_CLEAR, '0, ST_OK, 0, '0, 0, 0));

      // single reset pulse, released on a falling edge
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_pct = 0;
      foreach (directed_rows[i]) begin
         typed_pending = directed_rows[i].typed;
         typed_view    = directed_rows[i].view;
         send_word(directed_rows[i].op, directed_rows[i].val);
      end
      typed_pending = 1'b0;

      // random part in phases of different sender gaps
      foreach (phase_pct[p]) begin
         idle_pct = phase_pct[p];
         run_random(cmds_sent + RANDOM_WORDS / 3);
      end
      start <= 1'b0;

      // let every outstanding response land, then watch for strays
      while (stack_views_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && stack_views_due.size() == 0) begin
         $display("tb_typed_rpn_stack_engine passed");
      end else begin
         $display("tb_typed_rpn_stack_engine failed");
      end
      $finish;
   end

endmodule
